// File: src/bms_pkg.sv
package bms_pkg;

   // request codes
   localparam logic [1:0] REQ_START       = 2'd0;
   localparam logic [1:0] REQ_BYTE        = 2'd1;
   localparam logic [1:0] REQ_PLACEHOLDER = 2'd2;

   // frame kinds
   localparam logic [1:0] KIND_HEADER      = 2'd0;
   localparam logic [1:0] KIND_DATA        = 2'd1;
   localparam logic [1:0] KIND_FINAL       = 2'd2;
   localparam logic [1:0] KIND_PLACEHOLDER = 2'd3;

   // register indexes
   localparam logic CSR_SOURCE_ADDRESS = 1'b0;
   localparam logic CSR_ID_PREFIX      = 1'b1;

   // protocol constants
   localparam int unsigned   BYTES_PER_PACKET = 7;
   localparam logic [10:0]   MAX_LENGTH       = 11'd1785;
   localparam logic [7:0]    CTRL_BAM         = 8'd32;
   localparam logic [7:0]    PAD_BYTE         = 8'hFF;
   localparam logic [15:0]   HDR_GROUP        = 16'hECFF;
   localparam logic [7:0]    SOURCE_RESET     = 8'd118;
   localparam logic [4:0]    PREFIX_RESET     = 5'd24;

   // output queue depth, at least two
   localparam int unsigned   OUT_DEPTH = 4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] group_number;
      logic [10:0] total_len;
      logic [7:0]  payload_byte;
   } req_item_type;

   typedef struct packed {
      logic [28:0] frame_id;
      logic [1:0]  frame_kind;
      logic [7:0]  byte_0;
      logic [7:0]  byte_1;
      logic [7:0]  byte_2;
      logic [7:0]  byte_3;
      logic [7:0]  byte_4;
      logic [7:0]  byte_5;
      logic [7:0]  byte_6;
      logic [7:0]  byte_7;
      logic        last_of_run;
   } rsp_item_type;

   // frames produced by one item, pushed into the output queue together
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type frame_0;
      rsp_item_type frame_1;
   } push_type;

endpackage

// File: src/broadcast_multipacket_segmenter.sv
// channel    ports                          moves
// request    req_valid / req_ready          one req_data item per transfer
// response   rsp_valid / rsp_ready          one rsp_data frame per transfer
// config     csr_we, csr_index, csr_wdata   register write, no handshake
//
// items are registered on transfer, processed one per cycle while the queue has room
// a start of zero length puts two frames into the output queue, all else one or none
// first frame passes the input register and the output queue before it is offered
// input stalls only when the output queue cannot take two more frames
// reset (synchronous) empties the queue and ends any running message
module broadcast_multipacket_segmenter #(
   parameter int unsigned OUT_DEPTH = bms_pkg::OUT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bms_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bms_pkg::rsp_item_type rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata
);
   import bms_pkg::*;

   logic         held_valid_ff, held_valid_in;
   req_item_type held_item_ff;
   logic [7:0]   source_ff;
   logic [4:0]   prefix_ff;
   logic         room_for_two;
   logic         step;
   push_type     push;

   // input register
   assign step          = held_valid_ff && room_for_two;
   assign req_ready     = !held_valid_ff || room_for_two;
   assign held_valid_in = (req_valid && req_ready) || (held_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         held_item_ff <= req_data;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= SOURCE_RESET;
         prefix_ff <= PREFIX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE_ADDRESS: source_ff <= csr_wdata;
            CSR_ID_PREFIX:      prefix_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   bms_frame_build u_build (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (held_item_ff),
      .source_address (source_ff),
      .id_prefix      (prefix_ff),
      .push           (push)
   );

   bms_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

// File: src/bms_frame_build.sv
module bms_frame_build (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  bms_pkg::req_item_type item,
   input  logic [7:0]            source_address,
   input  logic [4:0]            id_prefix,
   output bms_pkg::push_type     push
);
   import bms_pkg::*;

   logic        active_ff, active_in;
   logic [15:0] group_ff, group_in;
   logic [10:0] expected_ff, expected_in;
   logic [10:0] taken_ff, taken_in;
   logic [7:0]  sequence_ff, sequence_in;
   logic [2:0]  fill_ff, fill_in;
   logic [7:0]  gather_ff [BYTES_PER_PACKET];

   logic [10:0] clamp_len;
   logic [24:0] count_prod;
   logic [7:0]  packets;
   logic [10:0] taken_inc;
   logic [2:0]  fill_inc;
   logic        final_frame;
   logic [7:0]  data_bytes [BYTES_PER_PACKET];
   rsp_item_type header_frame;
   rsp_item_type pad_frame;
   rsp_item_type data_frame;
   rsp_item_type hold_frame;

   // length clamp and packet count: ceil(len / 7) via reciprocal 9363 / 2^16
   assign clamp_len  = (item.total_len > MAX_LENGTH) ? MAX_LENGTH : item.total_len;
   assign count_prod = (25'(clamp_len) + 25'd6) * 25'd9363;
   assign packets    = count_prod[23:16];

   assign taken_inc   = taken_ff + 11'd1;
   assign fill_inc    = fill_ff + 3'd1;
   assign final_frame = (taken_inc >= expected_ff);

   // gathered bytes with the arriving byte bypassed in
   always_comb begin
      for (int i = 0; i < BYTES_PER_PACKET; i++) begin
         if (3'(i) == fill_ff) begin
            data_bytes[i] = item.payload_byte;
         end else if (3'(i) < fill_ff) begin
            data_bytes[i] = gather_ff[i];
         end else begin
            data_bytes[i] = PAD_BYTE;
         end
      end
   end

   // frame templates
   always_comb begin
      header_frame.frame_id    = {id_prefix, HDR_GROUP, source_address};
      header_frame.frame_kind  = KIND_HEADER;
      header_frame.byte_0      = CTRL_BAM;
      header_frame.byte_1      = clamp_len[7:0];
      header_frame.byte_2      = {5'd0, clamp_len[10:8]};
      header_frame.byte_3      = packets;
      header_frame.byte_4      = item.group_number[7:0];
      header_frame.byte_5      = item.group_number[15:8];
      header_frame.byte_6      = 8'd0;
      header_frame.byte_7      = 8'd0;
      header_frame.last_of_run = (clamp_len != 11'd0);

      pad_frame.frame_id    = {id_prefix, item.group_number, source_address};
      pad_frame.frame_kind  = KIND_FINAL;
      pad_frame.byte_0      = 8'd1;
      pad_frame.byte_1      = PAD_BYTE;
      pad_frame.byte_2      = PAD_BYTE;
      pad_frame.byte_3      = PAD_BYTE;
      pad_frame.byte_4      = PAD_BYTE;
      pad_frame.byte_5      = PAD_BYTE;
      pad_frame.byte_6      = PAD_BYTE;
      pad_frame.byte_7      = PAD_BYTE;
      pad_frame.last_of_run = 1'b1;

      hold_frame            = pad_frame;
      hold_frame.frame_kind = KIND_PLACEHOLDER;
      hold_frame.byte_0     = PAD_BYTE;

      data_frame.frame_id    = {id_prefix, group_ff, source_address};
      data_frame.frame_kind  = final_frame ? KIND_FINAL : KIND_DATA;
      data_frame.byte_0      = sequence_ff;
      data_frame.byte_1      = data_bytes[0];
      data_frame.byte_2      = data_bytes[1];
      data_frame.byte_3      = data_bytes[2];
      data_frame.byte_4      = data_bytes[3];
      data_frame.byte_5      = data_bytes[4];
      data_frame.byte_6      = data_bytes[5];
      data_frame.byte_7      = data_bytes[6];
      data_frame.last_of_run = 1'b1;
   end

   // per-item transfer control
   always_comb begin
      active_in     = active_ff;
      group_in      = group_ff;
      expected_in   = expected_ff;
      taken_in      = taken_ff;
      sequence_in   = sequence_ff;
      fill_in       = fill_ff;
      push.count    = 2'd0;
      push.frame_0  = header_frame;
      push.frame_1  = pad_frame;
      if (step) begin
         case (item.req_type)
            REQ_START: begin
               group_in    = item.group_number;
               expected_in = clamp_len;
               taken_in    = 11'd0;
               sequence_in = 8'd1;
               fill_in     = 3'd0;
               active_in   = (clamp_len != 11'd0);
               push.count  = (clamp_len == 11'd0) ? 2'd2 : 2'd1;
            end
            REQ_BYTE: begin
               if (active_ff) begin
                  taken_in = taken_inc;
                  fill_in  = fill_inc;
                  if ((fill_inc == 3'(BYTES_PER_PACKET)) || final_frame) begin
                     push.count   = 2'd1;
                     push.frame_0 = data_frame;
                     sequence_in  = sequence_ff + 8'd1;
                     fill_in      = 3'd0;
                     if (final_frame) begin
                        active_in = 1'b0;
                     end
                  end
               end
            end
            REQ_PLACEHOLDER: begin
               push.count   = 2'd1;
               push.frame_0 = hold_frame;
               active_in    = 1'b0;
               fill_in      = 3'd0;
            end
            default: begin
            end
         endcase
      end
   end

   // transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         group_ff    <= 16'd0;
         expected_ff <= 11'd0;
         taken_ff    <= 11'd0;
         sequence_ff <= 8'd1;
         fill_ff     <= 3'd0;
      end else begin
         active_ff   <= active_in;
         group_ff    <= group_in;
         expected_ff <= expected_in;
         taken_ff    <= taken_in;
         sequence_ff <= sequence_in;
         fill_ff     <= fill_in;
      end
   end

   // gather buffer, written at the fill position
   always_ff @(posedge clock) begin
      if (step && (item.req_type == REQ_BYTE) && active_ff) begin
         gather_ff[fill_ff] <= item.payload_byte;
      end
   end

endmodule

// File: src/bms_out_fifo.sv
module bms_out_fifo #(
   parameter int unsigned DEPTH = bms_pkg::OUT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bms_pkg::push_type     push,
   output logic                  room_for_two,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bms_pkg::rsp_item_type rsp_data
);
   import bms_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   rsp_item_type    entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   wr_ptr_p1, wr_ptr_p2;
   logic            pop;

   assign wr_ptr_p1 = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
   assign wr_ptr_p2 = (wr_ptr_p1 == LAST_PTR) ? '0 : wr_ptr_p1 + PW'(1);

   assign rsp_valid    = (count_ff != '0);
   assign rsp_data     = entry_ff[rd_ptr_ff];
   assign pop          = rsp_valid && rsp_ready;
   assign room_for_two = (count_ff <= CW'(DEPTH - 2));

   // pointer and occupancy update
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_p1;
         2'd2:    wr_ptr_in = wr_ptr_p2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // frame storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.frame_0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_p1] <= push.frame_1;
      end
   end

endmodule

// File: src/bms_checker.sv
module bms_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input bms_pkg::rsp_item_type rsp_data
);
   import bms_pkg::*;

   logic rsp_xfer;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // a waiting frame holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // header ends the run unless the message is empty
   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_data.frame_kind == KIND_HEADER) |->
         (rsp_data.byte_0 == CTRL_BAM) &&
         (rsp_data.last_of_run == ((rsp_data.byte_1 != 8'd0) || (rsp_data.byte_2 != 8'd0))))
      else $error("header control byte or last flag wrong");

   // an empty message's header is followed by its padding frame
   a_empty_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (rsp_data.frame_kind == KIND_HEADER) && !rsp_data.last_of_run |=>
         rsp_valid && (rsp_data.frame_kind == KIND_FINAL) && (rsp_data.byte_0 == 8'd1))
      else $error("empty message lost its padding frame");

   // data frames end the run and never carry sequence zero
   a_data_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && ((rsp_data.frame_kind == KIND_DATA) || (rsp_data.frame_kind == KIND_FINAL))
         |-> rsp_data.last_of_run && (rsp_data.byte_0 != 8'd0))
      else $error("data frame sequence or last flag wrong");

endmodule

bind broadcast_multipacket_segmenter bms_checker u_bms_checker (.*);
